/* hdl/srgb_lab_pkg.sv */
// srgb_lab_pkg: shared constants, widths and the sRGB linearization function
// for the sRGB to CIELAB converter. No dependencies.

package srgb_lab_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int LIN_FB        = 24;
  localparam int F_FB          = 20;

  localparam int LIN_W = LIN_FB + 1;   // linear channel, Q24, up to 1.0
  localparam int T_W   = 25;           // normalized tristimulus, Q24
  localparam int F_W   = F_FB + 1;     // companded value, Q20

  // tristimulus numerators (matrix row scaled so the divide is by the white point)
  localparam int XN_W = 41;
  localparam int YN_W = 38;
  localparam int ZN_W = 41;
  localparam longint X_DIV = 95047;
  localparam longint Y_DIV = 10000;
  localparam longint Z_DIV = 108883;
  localparam longint X_RND = 47523;
  localparam longint Y_RND = 5000;
  localparam longint Z_RND = 54441;

  // linear segment of the companding curve
  localparam int     LN_W     = 39;
  localparam int     LQ_W     = 18;
  localparam longint L_DIV    = 1856000;
  localparam longint L_MUL    = 7787 * 116;
  localparam longint L_OFS    = (longint'(16) << F_FB) * 16000 + 928000;
  localparam longint T_CUBE_MIN = (longint'(8856) << LIN_FB) / 1000000;

  // pipeline layout
  localparam int N_CBRT   = F_FB + 1;
  localparam int ST_LIN   = 0;
  localparam int ST_NUM   = 1;
  localparam int ST_DIV   = 2;
  localparam int N_DIV    = 3;
  localparam int ST_CMP   = ST_DIV + N_DIV;
  localparam int ST_OUT   = ST_CMP + N_CBRT;
  localparam int N_STAGES = ST_OUT + 1;

  // exact sRGB decode of one 8-bit code to Q24
  function automatic logic [LIN_W-1:0] lin_value(input int c);
    logic [383:0] rhs;
    logic [383:0] dpow;
    logic [383:0] lhs;
    logic [383:0] u;
    logic [LIN_W-1:0] y;
    logic [LIN_W-1:0] trial;
    longint small_v;
    if (c * 100000 <= 1031475) begin
      small_v = (((longint'(c) * 5) << LIN_FB) + 8236) / 16473;
      return LIN_W'(small_v);
    end
    u = 384'(1000 * c + 14025);
    rhs = 384'd1;
    for (int i = 0; i < 12; i++) rhs = rhs * u;
    rhs = rhs << 120;
    dpow = 384'd1;
    for (int i = 0; i < 12; i++) dpow = dpow * 384'd269025;
    y = '0;
    for (int b = LIN_FB; b >= 0; b--) begin
      trial = y | (LIN_W'(1) << b);
      lhs = dpow;
      for (int i = 0; i < 5; i++) lhs = lhs * 384'(trial);
      if (lhs <= rhs) y = trial;
    end
    return y;
  endfunction

endpackage

/* hdl/srgb_lab_cdiv.sv */
// srgb_lab_cdiv: rounding-free divide by a constant in three stages
// (reciprocal estimate, remainder, correction). Depends on nothing.

module srgb_lab_cdiv #(
  parameter longint DIV = 10000,
  parameter int     NW  = 38,
  parameter int     QW  = 25
) (
  input  logic          clk,
  input  logic [2:0]    en,
  input  logic [NW-1:0] num,
  output logic [QW-1:0] quo
);

  localparam int S  = $clog2(DIV) - 1;
  localparam int HW = NW - S;
  localparam int RW = $clog2(3 * DIV) + 1;
  localparam logic [63:0] ONE = 64'd1;
  localparam logic [HW-1:0] RECIP = HW'((ONE << NW) / 64'(DIV));
  localparam logic [RW-1:0] D1 = RW'(DIV);
  localparam logic [RW-1:0] D2 = RW'(2 * DIV);

  logic [HW-1:0]   est_a_r;
  logic [NW-1:0]   num_a_r;
  logic [HW-1:0]   est_b_r;
  logic [RW-1:0]   rem_b_r;
  logic [QW-1:0]   quo_r;
  logic [2*HW-1:0] prod;
  logic [NW-1:0]   qd;
  logic [NW-1:0]   rem_full;
  logic [HW-1:0]   est_fix;

  assign prod     = {{HW{1'b0}}, num[NW-1:S]} * {{HW{1'b0}}, RECIP};
  assign qd       = NW'(est_a_r) * NW'(DIV);
  assign rem_full = num_a_r - qd;

  always_comb begin
    if (rem_b_r >= D2) begin
      est_fix = est_b_r + HW'(2);
    end else if (rem_b_r >= D1) begin
      est_fix = est_b_r + HW'(1);
    end else begin
      est_fix = est_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      est_a_r <= prod[2*HW-1:HW];
      num_a_r <= num;
    end
    if (en[1]) begin
      est_b_r <= est_a_r;
      rem_b_r <= rem_full[RW-1:0];
    end
    if (en[2]) begin
      quo_r <= est_fix[QW-1:0];
    end
  end

  assign quo = quo_r;

endmodule

/* hdl/srgb_lab_comp.sv */
// srgb_lab_comp: CIELAB companding of one Q24 value to Q20, cube root one bit
// per stage, linear segment in parallel. Depends on srgb_lab_pkg, srgb_lab_cdiv.

module srgb_lab_comp (
  input  logic                           clk,
  input  logic [srgb_lab_pkg::N_CBRT-1:0] en,
  input  logic [srgb_lab_pkg::T_W-1:0]   t,
  output logic [srgb_lab_pkg::F_W-1:0]   f
);

  localparam int NS  = srgb_lab_pkg::N_CBRT;
  localparam int FW  = srgb_lab_pkg::F_W;
  localparam int R2W = 2 * FW;
  localparam int R3W = 64;
  localparam int TGW = srgb_lab_pkg::T_W + 3 * srgb_lab_pkg::F_FB - srgb_lab_pkg::LIN_FB;
  localparam int LQW = srgb_lab_pkg::LQ_W;
  localparam int LNW = srgb_lab_pkg::LN_W;

  logic [FW-1:0]  r_r   [NS];
  logic [R2W-1:0] r2_r  [NS];
  logic [R3W-1:0] r3_r  [NS];
  logic [TGW-1:0] tgt_r [NS];
  logic           big_r [NS];
  logic [LQW-1:0] flin_r [NS];
  logic [LNW-1:0] lnum_r;
  logic [LQW-1:0] flin_q;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lnum_r <= (t > srgb_lab_pkg::T_W'(srgb_lab_pkg::T_CUBE_MIN)) ? '0 :
                LNW'(LNW'(t[LQW-1:0]) * LNW'(srgb_lab_pkg::L_MUL)
                     + LNW'(srgb_lab_pkg::L_OFS));
    end
  end

  srgb_lab_cdiv #(
    .DIV (srgb_lab_pkg::L_DIV),
    .NW  (LNW),
    .QW  (LQW)
  ) u_lin_div (
    .clk (clk),
    .en  (en[3:1]),
    .num (lnum_r),
    .quo (flin_q)
  );

  for (genvar i = 0; i < NS; i++) begin : g_st
    localparam int B = NS - 1 - i;
    logic [FW-1:0]  r_p;
    logic [R2W-1:0] r2_p;
    logic [R3W-1:0] r3_p;
    logic [TGW-1:0] tgt_p;
    logic           big_p;
    logic [R3W-1:0] trial3;
    logic           take;

    if (i == 0) begin : g_first
      assign r_p   = '0;
      assign r2_p  = '0;
      assign r3_p  = '0;
      assign tgt_p = {t, {(TGW - srgb_lab_pkg::T_W){1'b0}}};
      assign big_p = t > srgb_lab_pkg::T_W'(srgb_lab_pkg::T_CUBE_MIN);
    end else begin : g_next
      assign r_p   = r_r[i-1];
      assign r2_p  = r2_r[i-1];
      assign r3_p  = r3_r[i-1];
      assign tgt_p = tgt_r[i-1];
      assign big_p = big_r[i-1];
    end

    assign trial3 = r3_p + ((R3W'(r2_p) * R3W'(3)) << B)
                  + ((R3W'(r_p) * R3W'(3)) << (2 * B)) + (R3W'(1) << (3 * B));
    assign take   = trial3 <= R3W'(tgt_p);

    always_ff @(posedge clk) begin
      if (en[i]) begin
        tgt_r[i] <= tgt_p;
        big_r[i] <= big_p;
        if (take) begin
          r_r[i]  <= r_p | (FW'(1) << B);
          r2_r[i] <= r2_p + (R2W'(r_p) << (B + 1)) + (R2W'(1) << (2 * B));
          r3_r[i] <= trial3;
        end else begin
          r_r[i]  <= r_p;
          r2_r[i] <= r2_p;
          r3_r[i] <= r3_p;
        end
      end
    end

    if (i == 4) begin : g_lin_first
      always_ff @(posedge clk) begin
        if (en[i]) flin_r[i] <= flin_q;
      end
    end else if (i > 4) begin : g_lin_next
      always_ff @(posedge clk) begin
        if (en[i]) flin_r[i] <= flin_r[i-1];
      end
    end else begin : g_lin_none
      assign flin_r[i] = '0;
    end
  end

  assign f = big_r[NS-1] ? r_r[NS-1] : FW'(flin_r[NS-1]);

endmodule

/* hdl/srgb_lab_out.sv */
// srgb_lab_out: L*, a*, b* from companded values, rounding and saturation,
// output register. Depends on srgb_lab_pkg.

module srgb_lab_out #(
  parameter int FRAC_BITS = srgb_lab_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [srgb_lab_pkg::F_W-1:0] fx,
  input  logic [srgb_lab_pkg::F_W-1:0] fy,
  input  logic [srgb_lab_pkg::F_W-1:0] fz,
  output logic [14:0]                  lightness,
  output logic signed [15:0]           green_red_axis,
  output logic signed [15:0]           blue_yellow_axis
);

  localparam int     FB   = srgb_lab_pkg::F_FB;
  localparam longint L100 = longint'(100) << FRAC_BITS;
  localparam longint LIM  = (L100 > 32767) ? 32767 : L100;

  function automatic logic [15:0] axis_sat(input logic signed [31:0] n);
    logic [63:0] mag;
    logic [63:0] m;
    logic [63:0] neg_m;
    mag = n[31] ? 64'(-n) : 64'(n);
    m = ((mag << FRAC_BITS) + (64'd1 << (FB - 1))) >> FB;
    neg_m = -m;
    if (n[31]) begin
      return (m > 64'd32768) ? 16'h8000 : neg_m[15:0];
    end
    return (m > 64'd32767) ? 16'h7fff : m[15:0];
  endfunction

  logic signed [31:0] ln;
  logic signed [31:0] an;
  logic signed [31:0] bn;
  logic [63:0]        lmag;
  logic [14:0]        l_nxt;
  logic [14:0]        lightness_r;
  logic [15:0]        a_r;
  logic [15:0]        b_r;

  assign ln = $signed(32'(fy)) * 32'sd116 - (32'sd16 <<< FB);
  assign an = ($signed(32'(fx)) - $signed(32'(fy))) * 32'sd500;
  assign bn = ($signed(32'(fy)) - $signed(32'(fz))) * 32'sd200;
  assign lmag = ((64'(ln) << FRAC_BITS) + (64'd1 << (FB - 1))) >> FB;

  always_comb begin
    if (ln <= 0) begin
      l_nxt = '0;
    end else if (lmag > 64'(LIM)) begin
      l_nxt = 15'(LIM);
    end else begin
      l_nxt = lmag[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lightness_r <= l_nxt;
      a_r         <= axis_sat(an);
      b_r         <= axis_sat(bn);
    end
  end

  assign lightness        = lightness_r;
  assign green_red_axis   = $signed(a_r);
  assign blue_yellow_axis = $signed(b_r);

endmodule

/* hdl/srgb_to_cielab_converter_core.sv */
// srgb_to_cielab_converter_core: sRGB (8-bit) to CIELAB D65 pixel pipeline.
// Depends on srgb_lab_pkg, srgb_lab_cdiv, srgb_lab_comp, srgb_lab_out.
//
// Usage:
//   Input channel in_valid/in_ready carries one pixel word (in_red, in_green,
//   in_blue). Output channel out_valid/out_ready carries one Lab word
//   (out_lightness, out_green_red_axis, out_blue_yellow_axis), FRAC_BITS
//   fraction bits, rounded half away from zero and saturated.
//   From input accept to out_valid a word passes the table lookup, matrix,
//   three-stage constant divide, 21 cube-root bit stages and output stage.
//   Throughput: one word per cycle; each stage holds one word and moves
//   whenever the stage ahead is empty or moving.
//   Stall: when out_ready is low the words pack up behind the output
//   register; in_ready falls only once every stage holds a word.
//   Reset: rst_n (synchronous, active low) empties the pipeline; no other
//   state is kept between pixels.

module srgb_to_cielab_converter_core #(
  parameter int FRAC_BITS = srgb_lab_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        out_lightness,
  output logic signed [15:0] out_green_red_axis,
  output logic signed [15:0] out_blue_yellow_axis
);

  localparam int NSTG = srgb_lab_pkg::N_STAGES;
  localparam int LW   = srgb_lab_pkg::LIN_W;
  localparam int TW   = srgb_lab_pkg::T_W;
  localparam int FW   = srgb_lab_pkg::F_W;
  localparam int XNW  = srgb_lab_pkg::XN_W;
  localparam int YNW  = srgb_lab_pkg::YN_W;
  localparam int ZNW  = srgb_lab_pkg::ZN_W;
  localparam int SD   = srgb_lab_pkg::ST_DIV;
  localparam int SC   = srgb_lab_pkg::ST_CMP;
  localparam int NC   = srgb_lab_pkg::N_CBRT;

  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   en;

  logic [LW-1:0]  lin_tbl [256];
  logic [LW-1:0]  lr_r;
  logic [LW-1:0]  lg_r;
  logic [LW-1:0]  lb_r;
  logic [XNW-1:0] nx_r;
  logic [YNW-1:0] ny_r;
  logic [ZNW-1:0] nz_r;
  logic [TW-1:0]  tx;
  logic [TW-1:0]  ty;
  logic [TW-1:0]  tz;
  logic [FW-1:0]  fx;
  logic [FW-1:0]  fy;
  logic [FW-1:0]  fz;

  for (genvar g = 0; g < 256; g++) begin : g_tbl
    assign lin_tbl[g] = srgb_lab_pkg::lin_value(g);
  end

  always_comb begin
    en[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[srgb_lab_pkg::ST_LIN]) begin
      lr_r <= lin_tbl[in_red];
      lg_r <= lin_tbl[in_green];
      lb_r <= lin_tbl[in_blue];
    end
    if (en[srgb_lab_pkg::ST_NUM]) begin
      nx_r <= XNW'(lr_r) * XNW'(41240) + XNW'(lg_r) * XNW'(35760)
            + XNW'(lb_r) * XNW'(18050) + XNW'(srgb_lab_pkg::X_RND);
      ny_r <= YNW'(lr_r) * YNW'(2126) + YNW'(lg_r) * YNW'(7152)
            + YNW'(lb_r) * YNW'(722) + YNW'(srgb_lab_pkg::Y_RND);
      nz_r <= ZNW'(lr_r) * ZNW'(1930) + ZNW'(lg_r) * ZNW'(11920)
            + ZNW'(lb_r) * ZNW'(95050) + ZNW'(srgb_lab_pkg::Z_RND);
    end
  end

  srgb_lab_cdiv #(.DIV(srgb_lab_pkg::X_DIV), .NW(XNW), .QW(TW)) u_div_x (
    .clk (clk), .en (en[SD+2:SD]), .num (nx_r), .quo (tx)
  );
  srgb_lab_cdiv #(.DIV(srgb_lab_pkg::Y_DIV), .NW(YNW), .QW(TW)) u_div_y (
    .clk (clk), .en (en[SD+2:SD]), .num (ny_r), .quo (ty)
  );
  srgb_lab_cdiv #(.DIV(srgb_lab_pkg::Z_DIV), .NW(ZNW), .QW(TW)) u_div_z (
    .clk (clk), .en (en[SD+2:SD]), .num (nz_r), .quo (tz)
  );

  srgb_lab_comp u_comp_x (.clk(clk), .en(en[SC+NC-1:SC]), .t(tx), .f(fx));
  srgb_lab_comp u_comp_y (.clk(clk), .en(en[SC+NC-1:SC]), .t(ty), .f(fy));
  srgb_lab_comp u_comp_z (.clk(clk), .en(en[SC+NC-1:SC]), .t(tz), .f(fz));

  srgb_lab_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk              (clk),
    .en               (en[srgb_lab_pkg::ST_OUT]),
    .fx               (fx),
    .fy               (fy),
    .fz               (fz),
    .lightness        (out_lightness),
    .green_red_axis   (out_green_red_axis),
    .blue_yellow_axis (out_blue_yellow_axis)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pipeline not empty after reset");

  a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> &v_r)
    else $error("input stalled while a stage is empty");

  a_first_free: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_ready)
    else $error("first stage empty but input not ready");

  a_l_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lightness <= 15'd25600 || FRAC_BITS > 8))
    else $error("lightness above 100.0");

endmodule
